// ----- src/ntc_pkg.sv -----
// Shared constants and the calibration table of the NTC reading to temperature converter.
// No dependencies; every other file of the block but ntc_sample_if uses it by scoped names.
`timescale 1ns / 1ps

package ntc_pkg;

  localparam int TBL_SLOTS    = 64;
  localparam int TBL_IDX_BITS = 6;
  localparam int TBL_VAL_BITS = 10;
  localparam int OUT_BITS     = 12;
  // Temperature of the first table point, in tenths of a degree.
  localparam int BASE_DECI    = -400;

  // Expected ADC readings at 5 degree steps from -40 C, strictly descending.
  // Slots past the calibrated points read as zero.
  function automatic logic [TBL_VAL_BITS-1:0] tbl_value(input logic [TBL_IDX_BITS-1:0] idx);
    logic [TBL_VAL_BITS-1:0] val;
    case (idx)
      6'd0:    val = 10'd1010;
      6'd1:    val = 10'd1004;
      6'd2:    val = 10'd997;
      6'd3:    val = 10'd988;
      6'd4:    val = 10'd976;
      6'd5:    val = 10'd962;
      6'd6:    val = 10'd943;
      6'd7:    val = 10'd921;
      6'd8:    val = 10'd895;
      6'd9:    val = 10'd864;
      6'd10:   val = 10'd828;
      6'd11:   val = 10'd788;
      6'd12:   val = 10'd744;
      6'd13:   val = 10'd697;
      6'd14:   val = 10'd647;
      6'd15:   val = 10'd596;
      6'd16:   val = 10'd544;
      6'd17:   val = 10'd493;
      6'd18:   val = 10'd445;
      6'd19:   val = 10'd398;
      6'd20:   val = 10'd355;
      6'd21:   val = 10'd315;
      6'd22:   val = 10'd278;
      6'd23:   val = 10'd245;
      6'd24:   val = 10'd216;
      6'd25:   val = 10'd190;
      6'd26:   val = 10'd167;
      6'd27:   val = 10'd147;
      6'd28:   val = 10'd129;
      6'd29:   val = 10'd113;
      6'd30:   val = 10'd100;
      6'd31:   val = 10'd88;
      6'd32:   val = 10'd78;
      6'd33:   val = 10'd69;
      6'd34:   val = 10'd61;
      6'd35:   val = 10'd54;
      6'd36:   val = 10'd48;
      6'd37:   val = 10'd43;
      6'd38:   val = 10'd38;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ----- src/ntc_sample_if.sv -----
// Valid/ready channel that carries one ADC reading per item.
// Width is set by its own SAMPLE_BITS parameter, not taken from the top level.
`timescale 1ns / 1ps

interface ntc_sample_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

// ----- src/ntc_temp_if.sv -----
// Valid/ready channel that carries one temperature in tenths of a degree per item.
// Depends on ntc_pkg for the result width.
`timescale 1ns / 1ps

interface ntc_temp_if;
  logic                                valid;
  logic                                ready;
  logic signed [ntc_pkg::OUT_BITS-1:0] deci_celsius;

  modport source (output valid, output deci_celsius, input ready);
  modport sink   (input valid, input deci_celsius, output ready);
endinterface

// ----- src/ntc_adc_to_deci_celsius.sv -----
// NTC ADC reading to temperature converter: table search plus serial interpolation divide.
// Depends on ntc_pkg, ntc_sample_if and ntc_temp_if.
//
//   Channel  Dir  Payload                      Meaning
//   sample   in   raw_sample [SAMPLE_BITS-1:0]  ADC reading of the thermistor divider
//   result   out  deci_celsius [11:0] signed   temperature in 0.1 C
//
// Each item passes through the table search, the prep state, the divide and the finish state:
// one table entry is compared per cycle, then the restoring divider produces one quotient
// bit per cycle. sample.ready is high only while the sequencer idles.
// The finished item waits in the output register, so a new item can be taken while
// result is stalled. Reset (rst, synchronous) returns the sequencer to idle and drops
// result.valid.
`timescale 1ns / 1ps

module ntc_adc_to_deci_celsius #(
  parameter int TABLE_ENTRIES = 39,
  parameter int SAMPLE_BITS   = 10
) (
  input  logic         clk,
  input  logic         rst,
  ntc_sample_if.sink   sample,
  ntc_temp_if.source   result
);

  localparam int ENTRIES_CLAMPED = (TABLE_ENTRIES > ntc_pkg::TBL_SLOTS) ? ntc_pkg::TBL_SLOTS :
                                   ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
  localparam int LAST_SEG  = ENTRIES_CLAMPED - 2;
  localparam int VB        = ntc_pkg::TBL_VAL_BITS;
  localparam int IB        = ntc_pkg::TBL_IDX_BITS;
  localparam int EXT_BITS  = ((SAMPLE_BITS > VB) ? SAMPLE_BITS : VB) + 1;
  localparam int NUM_BITS  = EXT_BITS + 5;
  localparam int CNT_BITS  = $clog2(NUM_BITS + 1);
  localparam int SUM_BITS  = NUM_BITS + 2;
  localparam int OB        = ntc_pkg::OUT_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PREP,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  state_t                 state;
  logic [SAMPLE_BITS-1:0] raw;
  logic [IB-1:0]          k;
  logic [IB-1:0]          j;
  logic [VB-1:0]          div;
  logic                   div_zero;
  logic                   neg;
  logic [VB:0]            rem;
  logic [NUM_BITS-1:0]    quo;
  logic [CNT_BITS-1:0]    cnt;
  logic [SUM_BITS-1:0]    base;
  logic                   out_valid;
  logic [OB-1:0]          out_data;

  logic [VB-1:0]          tk;
  logic [VB-1:0]          tj;
  logic [VB-1:0]          tj1;
  logic [EXT_BITS-1:0]    delta;
  logic [EXT_BITS-1:0]    delta_abs;
  logic [EXT_BITS-2:0]    mag;
  logic [NUM_BITS-1:0]    num;
  logic [SUM_BITS-1:0]    base_next;
  logic [VB:0]            rem_shift;
  logic                   rem_ge;
  logic [SUM_BITS-1:0]    frac;
  logic [SUM_BITS-1:0]    sum;
  logic                   out_free;

  assign tk  = ntc_pkg::tbl_value(k);
  assign tj  = ntc_pkg::tbl_value(j);
  assign tj1 = ntc_pkg::tbl_value(j + IB'(1));

  // Signed distance from the segment start, then 50 times its magnitude by shift-and-add.
  assign delta     = EXT_BITS'(tj) - EXT_BITS'(raw);
  assign delta_abs = delta[EXT_BITS-1] ? (~delta + EXT_BITS'(1)) : delta;
  assign mag       = delta_abs[EXT_BITS-2:0];
  assign num       = NUM_BITS'({mag, 5'b0}) + NUM_BITS'({mag, 4'b0}) + NUM_BITS'({mag, 1'b0});
  assign base_next = SUM_BITS'(ntc_pkg::BASE_DECI) + SUM_BITS'({j, 5'b0}) +
                     SUM_BITS'({j, 4'b0}) + SUM_BITS'({j, 1'b0});

  assign rem_shift = {rem[VB-1:0], quo[NUM_BITS-1]};
  assign rem_ge    = rem_shift >= {1'b0, div};

  // The quotient truncates toward zero, so the sign is applied to the magnitude.
  assign frac = div_zero ? '0 : (neg ? (~SUM_BITS'(quo) + SUM_BITS'(1)) : SUM_BITS'(quo));
  assign sum  = base + frac;

  assign out_free = !out_valid || result.ready;

  assign sample.ready        = (state == ST_IDLE);
  assign result.valid        = out_valid;
  assign result.deci_celsius = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In the finish state the output register is reloaded instead of cleared.
      if (out_valid && result.ready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            raw   <= sample.raw_sample;
            k     <= '0;
            j     <= '0;
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          // Keep the last entry that is still at or above the reading.
          if (EXT_BITS'(tk) >= EXT_BITS'(raw)) begin
            j <= k;
          end
          if (k == IB'(LAST_SEG)) begin
            state <= ST_PREP;
          end else begin
            k <= k + IB'(1);
          end
        end
        ST_PREP: begin
          div      <= tj - tj1;
          div_zero <= (tj == tj1);
          neg      <= delta[EXT_BITS-1];
          quo      <= num;
          rem      <= '0;
          cnt      <= CNT_BITS'(NUM_BITS);
          base     <= base_next;
          state    <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (rem_ge) begin
            rem <= rem_shift - {1'b0, div};
          end else begin
            rem <= rem_shift;
          end
          quo <= {quo[NUM_BITS-2:0], rem_ge};
          cnt <= cnt - CNT_BITS'(1);
          if (cnt == CNT_BITS'(1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_data  <= sum[OB-1:0];
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for ntc_adc_to_deci_celsius: drives ADC readings, predicts each temperature.
// Depends on ntc_pkg, ntc_sample_if, ntc_temp_if and the converter top level.
`timescale 1ns / 1ps

module tb;

  localparam int CAL_POINTS  = 39;
  localparam int PHASE_ITEMS = 357;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 80;

  // Holds the temperatures still owed by the converter, oldest first.
  class deci_celsius_board;
    int cal_reading [CAL_POINTS] = '{
      1010, 1004, 997, 988, 976, 962, 943, 921,
      895, 864, 828, 788, 744, 697, 647, 596,
      544, 493, 445, 398, 355, 315, 278, 245,
      216, 190, 167, 147, 129, 113, 100, 88,
      78, 69, 61, 54, 48, 43, 38
    };
    logic signed [ntc_pkg::OUT_BITS-1:0] owed_temps [$];
    int mismatches = 0;

    // Picks the last segment whose upper reading is at or above the sample,
    // then interpolates; outside the table the end segments extrapolate.
    function logic signed [ntc_pkg::OUT_BITS-1:0] reading_to_deci(input logic [9:0] raw);
      int r;
      int seg;
      int span;
      int frac;
      int deci;
      r    = int'(raw);
      seg  = 0;
      frac = 0;
      for (int k = 0; k <= CAL_POINTS - 2; k++) begin
        if (cal_reading[k] >= r) seg = k;
      end
      span = cal_reading[seg] - cal_reading[seg + 1];
      if (span != 0) frac = (50 * (cal_reading[seg] - r)) / span;
      deci = -400 + 50 * seg + frac;
      return deci[ntc_pkg::OUT_BITS-1:0];
    endfunction

    function void note_sample(input logic [9:0] raw);
      owed_temps.push_back(reading_to_deci(raw));
    endfunction

    function void check_temp(input logic signed [ntc_pkg::OUT_BITS-1:0] got);
      logic signed [ntc_pkg::OUT_BITS-1:0] want;
      if (owed_temps.size() == 0) begin
        $display("%0t: unexpected deci_celsius %0d, expected none", $time, got);
        mismatches++;
      end else begin
        want = owed_temps.pop_front();
        if (got !== want) begin
          $display("%0t: deci_celsius expected %0d, actual %0d", $time, want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   src_idle_pct  = 0;
  int   snk_stall_pct = 0;
  int   quiet_cycles  = 0;

  deci_celsius_board board = new();

  ntc_sample_if #(.SAMPLE_BITS(10)) adc_ch ();
  ntc_temp_if                       temp_ch ();

  ntc_adc_to_deci_celsius dut (
    .clk    (clk),
    .rst    (rst),
    .sample (adc_ch),
    .result (temp_ch)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver side: stalls at the rate of the current phase.
  always @(posedge clk) begin
    temp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && adc_ch.valid && adc_ch.ready) board.note_sample(adc_ch.raw_sample);
    if (!rst && temp_ch.valid && temp_ch.ready) board.check_temp(temp_ch.deci_celsius);
  end

  always @(posedge clk) begin
    if (rst || (adc_ch.valid && adc_ch.ready) || (temp_ch.valid && temp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Called right after a rising edge; returns at the edge where the item is taken.
  task automatic send_reading(input logic [9:0] raw);
    while ($urandom_range(99) < src_idle_pct) begin
      adc_ch.valid <= 1'b0;
      @(posedge clk);
    end
    adc_ch.valid      <= 1'b1;
    adc_ch.raw_sample <= raw;
    do @(posedge clk); while (!adc_ch.ready);
  endtask

  // Mostly uniform readings, some hugging a calibration point and a few at 0 or 1023.
  task automatic send_random_readings(input int count);
    int k;
    int v;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) < 3) begin
        k = $urandom_range(CAL_POINTS - 1);
        v = board.cal_reading[k] + int'($urandom_range(2)) - 1;
      end else if ($urandom_range(19) == 0) begin
        v = ($urandom_range(1) == 1) ? 1023 : 0;
      end else begin
        v = $urandom_range(1023);
      end
      send_reading(v[9:0]);
    end
  endtask

  initial begin
    logic [9:0] edge_readings [] = '{
      10'd0, 10'd1023, 10'd1011, 10'd1010, 10'd1009, 10'd1004, 10'd997, 10'd988,
      10'd545, 10'd544, 10'd543, 10'd49, 10'd48, 10'd43, 10'd39, 10'd38,
      10'd37, 10'd1, 10'd512, 10'd682, 10'd341, 10'd1022
    };
    int idle_plan [4]  = '{0, 76, 0, 12};
    int stall_plan [4] = '{0, 0, 76, 12};

    rst               <= 1'b1;
    adc_ch.valid      <= 1'b0;
    adc_ch.raw_sample <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (edge_readings[i]) send_reading(edge_readings[i]);

    for (int p = 0; p < 4; p++) begin
      src_idle_pct  = idle_plan[p];
      snk_stall_pct = stall_plan[p];
      send_random_readings(PHASE_ITEMS);
    end
    adc_ch.valid <= 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;

    while (board.owed_temps.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (board.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
